@@ sv/assert_macros.svh @@
// Assertion macros for the glyph layout top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtl: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define GTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtl: next-cycle check failed");

`endif

@@ sv/gtl_pkg.sv @@
// Types, codes and helpers for the glyph text layout block.
`timescale 1ns / 1ps

package gtl_pkg;

  // item opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_END   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SCALE       = 2'd0;
  localparam logic [1:0] CFG_LINE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ASCENT      = 2'd2;
  localparam logic [1:0] CFG_MAX_WIDTH   = 2'd3;
  localparam int         CFG_W           = 23;

  localparam logic [15:0] SCALE_RST       = 16'd4096;
  localparam logic [15:0] LINE_HEIGHT_RST = 16'd4096;
  localparam logic [15:0] ASCENT_RST      = 16'd3072;
  localparam logic [22:0] MAX_WIDTH_RST   = 23'h7FFFFF;

  // result kinds
  localparam logic KIND_QUAD    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // character codes
  localparam logic [7:0] CODE_NEWLINE    = 8'd10;
  localparam logic [7:0] CODE_FIRST_PRNT = 8'd32;

  // texture space: atlas coordinate * TEX_UNITS / ATLAS_SIZE
  localparam int TEX_UNITS = 512;
  localparam int TEX_K     = 32;

  localparam logic [35:0] U23_MAX = 36'd8388607;

  typedef enum logic [2:0] {
    CLS_START,
    CLS_END,
    CLS_NEWLINE,
    CLS_SKIP,
    CLS_GLYPH
  } cls_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         char_code;
    logic [9:0]         atlas_x0;
    logic [9:0]         atlas_y0;
    logic [9:0]         atlas_x1;
    logic [9:0]         atlas_y1;
    logic signed [15:0] bearing_x;
    logic signed [15:0] bearing_y;
    logic [15:0]        pen_advance;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] quad_x;
    logic signed [23:0] quad_y;
    logic [22:0]        quad_w;
    logic [22:0]        quad_h;
    logic [9:0]         tex_u0;
    logic [9:0]         tex_v0;
    logic [9:0]         tex_u1;
    logic [9:0]         tex_v1;
    logic [22:0]        text_width;
    logic [22:0]        text_height;
    logic [15:0]        fit_count;
  } out_item_t;

  typedef struct packed {
    logic [9:0] y1;
    logic [9:0] x1;
    logic [9:0] y0;
    logic [9:0] x0;
  } box_t;

  typedef struct packed {
    logic [15:0] pen_advance;
    logic [15:0] bearing_y;
    logic [15:0] bearing_x;
  } metric_t;

  typedef struct packed {
    cls_e        cls;
    logic [23:0] start_x;
    logic [23:0] start_y;
    box_t        box;
    metric_t     metric;
  } mid_item_t;

  typedef struct packed {
    logic [15:0] scale;
    logic [15:0] line_height;
    logic [15:0] ascent;
    logic [22:0] max_width;
  } cfg_t;

  // two's complement 25 -> 24 bit saturation
  function automatic logic [23:0] sat_s24(input logic [24:0] v);
    if (v[24] != v[23]) begin
      return v[24] ? 24'h800000 : 24'h7FFFFF;
    end
    return v[23:0];
  endfunction

  function automatic logic [23:0] sat_u24(input logic [24:0] v);
    return v[24] ? 24'hFFFFFF : v[23:0];
  endfunction

  function automatic logic [22:0] sat_u23(input logic [35:0] v);
    return (v > U23_MAX) ? 23'h7FFFFF : v[22:0];
  endfunction

endpackage

@@ sv/glyph_text_layout.sv @@
// Top level of the glyph text layout block: front end, queues, back end.
// Path: front-end register, middle queue, multiply register, then the output queue.
// Throughput: one item per cycle; when the result queue lacks room the input stalls.
// Glyph loads finish in the front end in the cycle of acceptance and make no result.
// Reset: async active low; config, pen state and table valid bits reset at once, no sweep.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glyph_text_layout #(
  parameter int GLYPH_SLOTS = 128,
  parameter int ATLAS_SIZE  = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item input queue
  input  logic                         push,
  input  gtl_pkg::in_item_t            in_item_i,
  output logic                         full,
  // result output queue
  output logic                         empty,
  input  logic                         pop,
  output gtl_pkg::out_item_t           out_item_o,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [gtl_pkg::CFG_W-1:0]    cfg_wdata_i
);

  import gtl_pkg::*;

  // two-entry queue decouples table reads from the pen pipeline;
  // four result slots cover the in-flight item plus downstream stalls
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  cfg_t      cfg_q;
  logic      mid_push, mid_full, mid_empty, mid_pop;
  mid_item_t mid_wr, mid_rd;
  logic      out_push, out_full;
  out_item_t out_wr;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_cnt;

  // configuration registers; user must write only while the block is idle (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{scale:       SCALE_RST,
                 line_height: LINE_HEIGHT_RST,
                 ascent:      ASCENT_RST,
                 max_width:   MAX_WIDTH_RST};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCALE:       cfg_q.scale       <= cfg_wdata_i[15:0];
        CFG_LINE_HEIGHT: cfg_q.line_height <= cfg_wdata_i[15:0];
        CFG_ASCENT:      cfg_q.ascent      <= cfg_wdata_i[15:0];
        CFG_MAX_WIDTH:   cfg_q.max_width   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front end: table loads, classification, table read
  gtl_front #(
    .GLYPH_SLOTS(GLYPH_SLOTS),
    .ATLAS_SIZE (ATLAS_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .mid_push_o (mid_push),
    .mid_item_o (mid_wr),
    .mid_full_i (mid_full)
  );

  // classified items waiting for the back end
  gtl_fifo #(
    .WIDTH($bits(mid_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wr),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rd),
    .empty_o (mid_empty),
    .count_o ()
  );

  // back end: scaling multiplies, then pen and measurement update
  gtl_back #(
    .ATLAS_SIZE(ATLAS_SIZE),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_rd),
    .mid_pop_o   (mid_pop),
    .out_cnt_i   (out_cnt),
    .out_push_o  (out_push),
    .out_item_o  (out_wr)
  );

  // result queue seen by the consumer
  gtl_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wr),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty),
    .count_o (out_cnt)
  );

  // credit scheme in the back end must never push into a full result queue
  `GTL_ASSERT_IMP(a_out_no_overflow, clk_i, rst_ni, out_push, !out_full)
  // front end must hold its item rather than push into a full middle queue
  `GTL_ASSERT_IMP(a_mid_no_overflow, clk_i, rst_ni, mid_push, !mid_full)
  // an accepted non-load item is queued next cycle or stalls the input
  `GTL_ASSERT_NXT(a_item_queued, clk_i, rst_ni,
                  push && !full && (in_item_i.opcode != OP_LOAD), mid_push || full)

endmodule

@@ sv/gtl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ sv/gtl_fifo.sv @@
// Small register FIFO with first-word fall-through output.
`timescale 1ns / 1ps

module gtl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int             PW       = $clog2(DEPTH);
  localparam int             CW       = $clog2(DEPTH + 1);
  localparam logic [CW-1:0]  CNT_FULL = CW'(DEPTH);
  localparam logic [PW-1:0]  PTR_LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

@@ sv/gtl_front.sv @@
// Front end: accepts items, loads the glyph table, classifies characters.
`timescale 1ns / 1ps

module gtl_front #(
  parameter int GLYPH_SLOTS = 128,
  parameter int ATLAS_SIZE  = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gtl_pkg::in_item_t   item_i,
  output logic                full_o,
  output logic                mid_push_o,
  output gtl_pkg::mid_item_t  mid_item_o,
  input  logic                mid_full_i
);

  import gtl_pkg::*;

  localparam int          IDX_W       = $clog2(GLYPH_SLOTS);
  localparam logic [12:0] ATLAS_LIM_W = 13'(ATLAS_SIZE);
  localparam logic [9:0]  ATLAS_LIM   = ATLAS_LIM_W[9:0];
  localparam logic [8:0]  SLOTS_LIM   = 9'(GLYPH_SLOTS);

  function automatic logic [9:0] clamp_coord(input logic [9:0] c);
    return ({3'b000, c} > ATLAS_LIM_W) ? ATLAS_LIM : c;
  endfunction

  logic                   accept, is_load, load_hit, rd_en;
  cls_e                   cls;
  logic [IDX_W-1:0]       slot;
  box_t                   wr_box, rd_box;
  metric_t                wr_met, rd_met;
  logic [GLYPH_SLOTS-1:0] slot_vld_q;

  logic                   s1_vld_q, s1_hit_q;
  cls_e                   s1_cls_q;
  logic [23:0]            s1_sx_q, s1_sy_q;

  assign full_o   = s1_vld_q && mid_full_i;
  assign accept   = push_i && !full_o;
  assign is_load  = (item_i.opcode == OP_LOAD);
  assign load_hit = is_load && ({1'b0, item_i.char_code} < SLOTS_LIM);
  assign slot     = item_i.char_code[IDX_W-1:0];
  assign rd_en    = accept && (cls == CLS_GLYPH);

  always_comb begin
    case (item_i.opcode)
      OP_START: cls = CLS_START;
      OP_END:   cls = CLS_END;
      OP_CHAR: begin
        if (item_i.char_code == CODE_NEWLINE) begin
          cls = CLS_NEWLINE;
        end else if (item_i.char_code < CODE_FIRST_PRNT || item_i.char_code[7]) begin
          cls = CLS_SKIP;
        end else begin
          cls = CLS_GLYPH;
        end
      end
      default:  cls = CLS_SKIP;  // loads never leave the front end
    endcase
  end

  always_comb begin
    wr_box.x0          = clamp_coord(item_i.atlas_x0);
    wr_box.y0          = clamp_coord(item_i.atlas_y0);
    wr_box.x1          = clamp_coord(item_i.atlas_x1);
    wr_box.y1          = clamp_coord(item_i.atlas_y1);
    wr_met.bearing_x   = item_i.bearing_x;
    wr_met.bearing_y   = item_i.bearing_y;
    wr_met.pen_advance = item_i.pen_advance;
  end

  gtl_ram #(
    .WIDTH($bits(box_t)),
    .DEPTH(GLYPH_SLOTS)
  ) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (accept && load_hit),
    .waddr_i (slot),
    .wdata_i (wr_box),
    .re_i    (rd_en),
    .raddr_i (slot),
    .rdata_o (rd_box)
  );

  gtl_ram #(
    .WIDTH($bits(metric_t)),
    .DEPTH(GLYPH_SLOTS)
  ) u_metric_ram (
    .clk_i   (clk_i),
    .we_i    (accept && load_hit),
    .waddr_i (slot),
    .wdata_i (wr_met),
    .re_i    (rd_en),
    .raddr_i (slot),
    .rdata_o (rd_met)
  );

  // never-loaded slots read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (accept && load_hit) begin
      slot_vld_q[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (!full_o) begin
      s1_vld_q <= accept && !is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cls_q <= cls;
      s1_sx_q  <= item_i.start_x;
      s1_sy_q  <= item_i.start_y;
      s1_hit_q <= rd_en && slot_vld_q[slot];
    end
  end

  assign mid_push_o = s1_vld_q && !mid_full_i;

  always_comb begin
    mid_item_o.cls     = s1_cls_q;
    mid_item_o.start_x = s1_sx_q;
    mid_item_o.start_y = s1_sy_q;
    mid_item_o.box     = s1_hit_q ? rd_box : '0;
    mid_item_o.metric  = s1_hit_q ? rd_met : '0;
  end

endmodule

@@ sv/gtl_back.sv @@
// Back end: scales glyph metrics, tracks the pen and builds result items.
`timescale 1ns / 1ps

module gtl_back #(
  parameter int ATLAS_SIZE = 512,
  parameter int OUT_DEPTH  = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gtl_pkg::cfg_t                  cfg_i,
  input  logic                           mid_empty_i,
  input  gtl_pkg::mid_item_t             mid_item_i,
  output logic                           mid_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_cnt_i,
  output logic                           out_push_o,
  output gtl_pkg::out_item_t             out_item_o
);

  import gtl_pkg::*;

  localparam int          CW           = $clog2(OUT_DEPTH + 1);
  localparam logic [CW:0] CREDIT_LIM   = (CW + 1)'(OUT_DEPTH);
  localparam int          TEX_SH       = TEX_K - $clog2(TEX_UNITS);
  localparam logic [63:0] TEX_MUL_WIDE =
    ((64'd1 << TEX_K) + 64'(ATLAS_SIZE) - 64'd1) / 64'(ATLAS_SIZE);
  localparam logic [27:0] TEX_MUL      = TEX_MUL_WIDE[27:0];

  // exact floor(c * TEX_UNITS / ATLAS_SIZE) by reciprocal multiply
  function automatic logic [9:0] tex_of(input logic [9:0] c);
    logic [37:0] p;
    p = 38'(c) * 38'(TEX_MUL);
    return p[TEX_SH+9:TEX_SH];
  endfunction

  // ---------------- multiply stage ----------------
  box_t               bx;
  metric_t            mt;
  logic [9:0]         gw, gh;
  logic [31:0]        adv_prod, lh_prod;
  logic signed [16:0] scale_s;
  logic signed [32:0] bx_prod;
  logic signed [16:0] ay_sum;
  logic signed [33:0] ay_prod;
  logic [25:0]        qw_prod, qh_prod;
  logic [CW:0]        credit;

  logic               b_vld_q;
  cls_e               b_cls_q;
  logic [23:0]        b_sx_q, b_sy_q;
  logic [19:0]        b_adv_q;
  logic [20:0]        b_bxs_q;
  logic [21:0]        b_ays_q;
  logic               b_gw_nz_q;
  logic [22:0]        b_qw_q, b_qh_q;
  logic [9:0]         b_tu0_q, b_tv0_q, b_tu1_q, b_tv1_q;
  logic [19:0]        lh_q;

  // pop only when the result queue has room for everything in flight
  assign credit    = {1'b0, out_cnt_i} + (CW + 1)'(b_vld_q);
  assign mid_pop_o = !mid_empty_i && (credit < CREDIT_LIM);

  always_comb begin
    bx       = mid_item_i.box;
    mt       = mid_item_i.metric;
    gw       = (bx.x1 > bx.x0) ? bx.x1 - bx.x0 : '0;
    gh       = (bx.y1 > bx.y0) ? bx.y1 - bx.y0 : '0;
    adv_prod = 32'(mt.pen_advance) * 32'(cfg_i.scale) + 32'd2048;
    lh_prod  = 32'(cfg_i.line_height) * 32'(cfg_i.scale) + 32'd2048;
    scale_s  = $signed({1'b0, cfg_i.scale});
    bx_prod  = 33'($signed(mt.bearing_x)) * 33'(scale_s) + 33'sd2048;
    ay_sum   = 17'($signed(cfg_i.ascent)) + 17'($signed(mt.bearing_y));
    ay_prod  = 34'(ay_sum) * 34'(scale_s) + 34'sd2048;
    // at most 1023 * 65535 / 16, so the Q15.8 extent never saturates
    qw_prod  = 26'(gw) * 26'(cfg_i.scale) + 26'd8;
    qh_prod  = 26'(gh) * 26'(cfg_i.scale) + 26'd8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      lh_q    <= 20'd4096;
    end else begin
      b_vld_q <= mid_pop_o;
      lh_q    <= lh_prod[31:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      b_cls_q   <= mid_item_i.cls;
      b_sx_q    <= mid_item_i.start_x;
      b_sy_q    <= mid_item_i.start_y;
      b_adv_q   <= adv_prod[31:12];
      b_bxs_q   <= bx_prod[32:12];
      b_ays_q   <= ay_prod[33:12];
      b_gw_nz_q <= (gw != '0);
      b_qw_q    <= {1'b0, qw_prod[25:4]};
      b_qh_q    <= {1'b0, qh_prod[25:4]};
      b_tu0_q   <= tex_of(bx.x0);
      b_tv0_q   <= tex_of(bx.y0);
      b_tu1_q   <= tex_of(bx.x1);
      b_tv1_q   <= tex_of(bx.y1);
    end
  end

  // ---------------- pen / measurement stage ----------------
  logic [23:0] pen_x_q, pen_y_q, origin_x_q, line_run_q, widest_q, fit_run_q;
  logic [15:0] line_total_q, char_idx_q, fit_val_q;
  logic        fit_vld_q;
  logic [23:0] pen_x_d, pen_y_d, origin_x_d, line_run_d, widest_d, fit_run_d;
  logic [15:0] line_total_d, char_idx_d, fit_val_d;
  logic        fit_vld_d;

  logic [23:0] pen_x_adv, pen_y_nl, qx, qy, run_add, fit_add, w_max;
  logic [15:0] idx_inc, total_inc;
  logic [35:0] h_prod;
  logic        fit_hit;

  always_comb begin
    pen_x_adv = sat_s24({pen_x_q[23], pen_x_q} + 25'(b_adv_q));
    pen_y_nl  = sat_s24({pen_y_q[23], pen_y_q} + 25'(lh_q));
    qx        = sat_s24({pen_x_q[23], pen_x_q} + {{4{b_bxs_q[20]}}, b_bxs_q});
    qy        = sat_s24({pen_y_q[23], pen_y_q} + {{3{b_ays_q[21]}}, b_ays_q});
    run_add   = sat_u24({1'b0, line_run_q} + 25'(b_adv_q));
    fit_add   = sat_u24({1'b0, fit_run_q} + 25'(b_adv_q));
    fit_hit   = !fit_vld_q && (fit_add > {1'b0, cfg_i.max_width});
    w_max     = (line_run_q > widest_q) ? line_run_q : widest_q;
    idx_inc   = (char_idx_q == 16'hFFFF) ? char_idx_q : char_idx_q + 16'd1;
    total_inc = (line_total_q == 16'hFFFF) ? line_total_q : line_total_q + 16'd1;
    h_prod    = 36'(line_total_q) * 36'(lh_q);
  end

  always_comb begin
    pen_x_d      = pen_x_q;
    pen_y_d      = pen_y_q;
    origin_x_d   = origin_x_q;
    line_run_d   = line_run_q;
    widest_d     = widest_q;
    fit_run_d    = fit_run_q;
    line_total_d = line_total_q;
    char_idx_d   = char_idx_q;
    fit_vld_d    = fit_vld_q;
    fit_val_d    = fit_val_q;
    if (b_vld_q) begin
      case (b_cls_q)
        CLS_START: begin
          pen_x_d      = b_sx_q;
          pen_y_d      = b_sy_q;
          origin_x_d   = b_sx_q;
          line_run_d   = '0;
          widest_d     = '0;
          fit_run_d    = '0;
          line_total_d = 16'd1;
          char_idx_d   = '0;
          fit_vld_d    = 1'b0;
          fit_val_d    = '0;
        end
        CLS_NEWLINE: begin
          char_idx_d   = idx_inc;
          pen_x_d      = origin_x_q;
          pen_y_d      = pen_y_nl;
          widest_d     = w_max;
          line_run_d   = '0;
          line_total_d = total_inc;
        end
        CLS_SKIP: begin
          char_idx_d = idx_inc;
        end
        CLS_GLYPH: begin
          char_idx_d = idx_inc;
          pen_x_d    = pen_x_adv;
          line_run_d = run_add;
          fit_run_d  = fit_add;
          if (fit_hit) begin
            fit_vld_d = 1'b1;
            fit_val_d = char_idx_q;
          end
        end
        default: ;  // end of text leaves state alone
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q      <= '0;
      pen_y_q      <= '0;
      origin_x_q   <= '0;
      line_run_q   <= '0;
      widest_q     <= '0;
      fit_run_q    <= '0;
      line_total_q <= 16'd1;
      char_idx_q   <= '0;
      fit_vld_q    <= 1'b0;
      fit_val_q    <= '0;
    end else begin
      pen_x_q      <= pen_x_d;
      pen_y_q      <= pen_y_d;
      origin_x_q   <= origin_x_d;
      line_run_q   <= line_run_d;
      widest_q     <= widest_d;
      fit_run_q    <= fit_run_d;
      line_total_q <= line_total_d;
      char_idx_q   <= char_idx_d;
      fit_vld_q    <= fit_vld_d;
      fit_val_q    <= fit_val_d;
    end
  end

  assign out_push_o = b_vld_q &&
                      (((b_cls_q == CLS_GLYPH) && b_gw_nz_q) || (b_cls_q == CLS_END));

  always_comb begin
    out_item_o = '0;
    if (b_cls_q == CLS_END) begin
      out_item_o.kind        = KIND_SUMMARY;
      out_item_o.text_width  = sat_u23(36'(w_max));
      out_item_o.text_height = sat_u23(h_prod);
      out_item_o.fit_count   = fit_vld_q ? fit_val_q : char_idx_q;
    end else begin
      out_item_o.kind   = KIND_QUAD;
      out_item_o.quad_x = qx;
      out_item_o.quad_y = qy;
      out_item_o.quad_w = b_qw_q;
      out_item_o.quad_h = b_qh_q;
      out_item_o.tex_u0 = b_tu0_q;
      out_item_o.tex_v0 = b_tv0_q;
      out_item_o.tex_u1 = b_tu1_q;
      out_item_o.tex_v1 = b_tv1_q;
    end
  end

endmodule

@@ bench/layout_mirror_pkg.sv @@
// Text layout mirror: tracks table, pen and config, predicts and checks result items.
`timescale 1ns / 1ps

package layout_mirror_pkg;
  import gtl_pkg::*;

  localparam int     TBL_SLOTS = 128;
  localparam int     ATLAS_PIX = 512;
  localparam int     PRINT_END = 128;
  localparam longint S24_HI    = 64'sd8388607;
  localparam longint S24_LO    = -64'sd8388608;
  localparam longint U23_HI    = 64'sd8388607;
  localparam longint U24_HI    = 64'sd16777215;

  class layout_mirror;
    cfg_t               regs;
    box_t               boxes[TBL_SLOTS];
    metric_t            metrics[TBL_SLOTS];
    logic signed [23:0] pen_x, pen_y, origin_x;
    logic [23:0]        line_run, widest_line, fit_run;
    logic [15:0]        line_total, char_index, fit_at;
    bit                 fit_found;
    out_item_t          due[$];
    int                 n_items, n_quads, n_summaries, n_bad;

    function new();
      regs = '{scale: SCALE_RST, line_height: LINE_HEIGHT_RST, ascent: ASCENT_RST,
               max_width: MAX_WIDTH_RST};
      foreach (boxes[i]) begin
        boxes[i] = '0;
        metrics[i] = '0;
      end
      restart(24'sd0, 24'sd0);
    endfunction

    function void restart(logic signed [23:0] x, logic signed [23:0] y);
      pen_x = x;
      pen_y = y;
      origin_x = x;
      line_run = '0;
      widest_line = '0;
      line_total = 16'd1;
      fit_run = '0;
      char_index = '0;
      fit_found = 1'b0;
      fit_at = '0;
    endfunction

    // round(a * scale / 2^sh), ties up; arithmetic shift floors negatives
    function longint scaled(longint a, int sh);
      longint sc;
      sc = longint'(regs.scale);
      return (a * sc + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function logic [9:0] clamp_atlas(logic [9:0] c);
      return (c > 10'(ATLAS_PIX)) ? 10'(ATLAS_PIX) : c;
    endfunction

    function logic [9:0] tex_of(logic [9:0] c);
      return 10'((int'(c) * TEX_UNITS) / ATLAS_PIX);
    endfunction

    function void set_reg(logic [1:0] idx, logic [22:0] v);
      case (idx)
        CFG_SCALE:       regs.scale = v[15:0];
        CFG_LINE_HEIGHT: regs.line_height = v[15:0];
        CFG_ASCENT:      regs.ascent = v[15:0];
        CFG_MAX_WIDTH:   regs.max_width = v;
      endcase
    endfunction

    function void take_item(in_item_t it);
      out_item_t   r;
      box_t        b;
      metric_t     m;
      longint      adv, lh, gw, gh;
      logic [15:0] my_idx;
      logic [7:0]  code;
      n_items++;
      code = it.char_code;
      r = '0;
      lh = scaled(longint'(regs.line_height), 12);
      case (it.opcode)
        OP_LOAD: begin
          if (code < TBL_SLOTS) begin
            boxes[code[6:0]] = '{y1: clamp_atlas(it.atlas_y1), x1: clamp_atlas(it.atlas_x1),
                                 y0: clamp_atlas(it.atlas_y0), x0: clamp_atlas(it.atlas_x0)};
            metrics[code[6:0]] = '{pen_advance: it.pen_advance, bearing_y: it.bearing_y,
                                   bearing_x: it.bearing_x};
          end
        end
        OP_START: restart(it.start_x, it.start_y);
        OP_END: begin
          r.kind = KIND_SUMMARY;
          r.text_width = 23'(clip(longint'((line_run > widest_line) ? line_run : widest_line),
                                  0, U23_HI));
          r.text_height = 23'(clip(longint'(line_total) * lh, 0, U23_HI));
          r.fit_count = fit_found ? fit_at : char_index;
          due.push_back(r);
        end
        OP_CHAR: begin
          my_idx = char_index;
          if (char_index != 16'hFFFF) char_index++;
          if (code == CODE_NEWLINE) begin
            pen_x = origin_x;
            pen_y = 24'(clip(longint'(pen_y) + lh, S24_LO, S24_HI));
            if (line_run > widest_line) widest_line = line_run;
            line_run = '0;
            if (line_total != 16'hFFFF) line_total++;
          end else if (code >= CODE_FIRST_PRNT && code < PRINT_END && code < TBL_SLOTS) begin
            b = boxes[code[6:0]];
            m = metrics[code[6:0]];
            gw = (b.x1 > b.x0) ? longint'(b.x1 - b.x0) : 0;
            gh = (b.y1 > b.y0) ? longint'(b.y1 - b.y0) : 0;
            adv = scaled(longint'(m.pen_advance), 12);
            if (gw != 0) begin
              r.kind = KIND_QUAD;
              r.quad_x = 24'(clip(longint'(pen_x) + scaled(longint'($signed(m.bearing_x)), 12),
                                  S24_LO, S24_HI));
              r.quad_y = 24'(clip(longint'(pen_y)
                                  + scaled(longint'($signed(regs.ascent))
                                           + longint'($signed(m.bearing_y)), 12),
                                  S24_LO, S24_HI));
              r.quad_w = 23'(clip(scaled(gw, 4), 0, U23_HI));
              r.quad_h = 23'(clip(scaled(gh, 4), 0, U23_HI));
              r.tex_u0 = tex_of(b.x0);
              r.tex_v0 = tex_of(b.y0);
              r.tex_u1 = tex_of(b.x1);
              r.tex_v1 = tex_of(b.y1);
              due.push_back(r);
            end
            pen_x = 24'(clip(longint'(pen_x) + adv, S24_LO, S24_HI));
            line_run = 24'(clip(longint'(line_run) + adv, 0, U24_HI));
            fit_run = 24'(clip(longint'(fit_run) + adv, 0, U24_HI));
            if (!fit_found && fit_run > regs.max_width) begin
              fit_found = 1'b1;
              fit_at = my_idx;
            end
          end
        end
      endcase
    endfunction

    function void cmp(string name, logic signed [63:0] want, logic signed [63:0] seen);
      if (want !== seen) begin
        n_bad++;
        if (n_bad <= 10) $display("mismatch on %s: expected %0d, got %0d", name, want, seen);
      end
    endfunction

    function void match_result(out_item_t got);
      out_item_t e;
      if (due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("result item with nothing due: %p", got);
        return;
      end
      e = due.pop_front();
      if (e.kind == KIND_QUAD) n_quads++;
      else n_summaries++;
      cmp("kind", e.kind, got.kind);
      cmp("quad_x", e.quad_x, got.quad_x);
      cmp("quad_y", e.quad_y, got.quad_y);
      cmp("quad_w", e.quad_w, got.quad_w);
      cmp("quad_h", e.quad_h, got.quad_h);
      cmp("tex_u0", e.tex_u0, got.tex_u0);
      cmp("tex_v0", e.tex_v0, got.tex_v0);
      cmp("tex_u1", e.tex_u1, got.tex_u1);
      cmp("tex_v1", e.tex_v1, got.tex_v1);
      cmp("text_width", e.text_width, got.text_width);
      cmp("text_height", e.text_height, got.text_height);
      cmp("fit_count", e.fit_count, got.fit_count);
    endfunction
  endclass

endpackage

@@ bench/tb_glyph_text_layout.sv @@
// Testbench top for the glyph text layout block: random text streams against a mirror.
`timescale 1ns / 1ps

module tb_glyph_text_layout;
  import gtl_pkg::*;
  import layout_mirror_pkg::*;

  // drain tail: margin for items still inside the block
  localparam int TAIL_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  in_item_t    in_item = '0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_SCALE;
  logic [22:0] cfg_wdata = '0;

  layout_mirror mirror;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_left = 0;   // receiver hold-off, counted down by the pop process
  int           loaded_codes[$]; // table slots that the text should hit

  glyph_text_layout dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .in_item_i  (in_item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Safety net: the slowest legal run is well under a tenth of this.
  initial begin
    #3_000_000;
    $display("timeout: stimulus or results stuck");
    $display("*** FAILED ***");
    $finish;
  end

  // Both handshakes sampled at the rising edge; drivers only move at the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) mirror.take_item(in_item);
      if (pop && !empty) mirror.match_result(out_item);
    end
  end

  // Result side: random stalls, plus a long hold-off when asked for.
  always @(negedge clk) begin
    if (!rst_n || hold_left > 0) begin
      pop <= 1'b0;
      if (hold_left > 0) hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Item builders. Every field starts random so all bits toggle, even the
  // fields that the opcode ignores.
  // ---------------------------------------------------------------------------
  function automatic in_item_t scrambled();
    in_item_t it;
    it.opcode      = 2'($urandom);
    it.char_code   = 8'($urandom);
    it.atlas_x0    = 10'($urandom);
    it.atlas_y0    = 10'($urandom);
    it.atlas_x1    = 10'($urandom);
    it.atlas_y1    = 10'($urandom);
    it.bearing_x   = 16'($urandom);
    it.bearing_y   = 16'($urandom);
    it.pen_advance = 16'($urandom);
    it.start_x     = 24'($urandom);
    it.start_y     = 24'($urandom);
    return it;
  endfunction

  function automatic in_item_t glyph_load(logic [7:0] code, logic [9:0] x0, logic [9:0] y0,
                                          logic [9:0] x1, logic [9:0] y1, logic [15:0] bx,
                                          logic [15:0] by, logic [15:0] adv);
    in_item_t it;
    it = scrambled();
    it.opcode = OP_LOAD;
    it.char_code = code;
    it.atlas_x0 = x0;
    it.atlas_y0 = y0;
    it.atlas_x1 = x1;
    it.atlas_y1 = y1;
    it.bearing_x = bx;
    it.bearing_y = by;
    it.pen_advance = adv;
    return it;
  endfunction

  function automatic in_item_t char_item(logic [7:0] code);
    in_item_t it;
    it = scrambled();
    it.opcode = OP_CHAR;
    it.char_code = code;
    return it;
  endfunction

  function automatic in_item_t start_item(logic [23:0] x, logic [23:0] y);
    in_item_t it;
    it = scrambled();
    it.opcode = OP_START;
    it.start_x = x;
    it.start_y = y;
    return it;
  endfunction

  function automatic in_item_t end_item();
    in_item_t it;
    it = scrambled();
    it.opcode = OP_END;
    return it;
  endfunction

  // Mostly printable slots with sane boxes; some control/high slots, wild boxes.
  function automatic in_item_t random_load();
    in_item_t it;
    int       roll, a, b;
    it = scrambled();
    it.opcode = OP_LOAD;
    roll = $urandom_range(99);
    if (roll < 90) it.char_code = 8'($urandom_range(32, 127));
    else if (roll < 95) it.char_code = 8'($urandom_range(0, 31));
    else it.char_code = 8'($urandom_range(128, 255));
    if ($urandom_range(99) < 80) begin
      a = $urandom_range(0, 512);
      b = $urandom_range(0, 512);
      it.atlas_x0 = 10'((a < b) ? a : b);
      it.atlas_x1 = 10'((a < b) ? b : a);
      a = $urandom_range(0, 512);
      b = $urandom_range(0, 512);
      it.atlas_y0 = 10'((a < b) ? a : b);
      it.atlas_y1 = 10'((a < b) ? b : a);
    end
    if ($urandom_range(99) < 60) it.pen_advance = 16'($urandom_range(0, 16'h2000));
    return it;
  endfunction

  // Text favors slots already loaded so that quads come out often.
  function automatic in_item_t random_char();
    in_item_t it;
    int       roll;
    it = scrambled();
    it.opcode = OP_CHAR;
    roll = $urandom_range(99);
    if (roll < 55 && loaded_codes.size() > 0)
      it.char_code = 8'(loaded_codes[$urandom_range(loaded_codes.size() - 1)]);
    else if (roll < 65) it.char_code = CODE_NEWLINE;
    else if (roll < 73) it.char_code = 8'($urandom_range(0, 31));
    else if (roll < 80) it.char_code = 8'($urandom_range(128, 255));
    else it.char_code = 8'($urandom_range(32, 127));
    return it;
  endfunction

  function automatic in_item_t random_start();
    in_item_t it;
    it = scrambled();
    it.opcode = OP_START;
    if ($urandom_range(99) < 60) begin
      it.start_x = 24'($urandom_range(0, 200000));
      it.start_y = 24'($urandom_range(0, 200000));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after acceptance.
  // push stays high into the next item when no gap is drawn.
  task automatic push_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Sender pause: everything due has arrived, then let loads/starts settle.
  task automatic drain();
    push <= 1'b0;
    while (mirror.due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // All four registers back to back; only called with the block idle.
  task automatic write_config(cfg_t c);
    logic [22:0] vals[4];
    int          i;
    vals[CFG_SCALE]       = 23'(c.scale);
    vals[CFG_LINE_HEIGHT] = 23'(c.line_height);
    vals[CFG_ASCENT]      = 23'(c.ascent);
    vals[CFG_MAX_WIDTH]   = c.max_width;
    for (i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= 2'(i);
      cfg_wdata <= vals[i];
      mirror.set_reg(2'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed texts (loads, start, chars, end) with some noise items
  // and texts missing their start or end. Ignored loads do not count.
  task automatic random_traffic(int n);
    in_item_t it;
    int       sent, len, k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 12) begin
        it = scrambled();
        push_item(it);
        if (!(it.opcode == OP_LOAD && it.char_code >= PRINT_END)) sent++;
      end else begin
        repeat ($urandom_range(0, 3)) begin
          it = random_load();
          push_item(it);
          if (it.char_code < PRINT_END) begin
            loaded_codes.push_back(int'(it.char_code));
            sent++;
          end
        end
        if ($urandom_range(9) != 0) begin
          push_item(random_start());
          sent++;
        end
        len = $urandom_range(0, 24);
        for (k = 0; k < len; k++) push_item(random_char());
        sent += len;
        if ($urandom_range(9) != 0) begin
          push_item(end_item());
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t plan[6];
    int   ph, c, x0;
    mirror = new();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 30;
    recv_idle_pct = 56;

    // Directed: work from reset state, then table extremes and every char class.
    push_item(char_item(8'd65));   // unloaded slot before any start: no quad
    push_item(end_item());         // summary straight from reset state
    push_item(glyph_load(8'd65, 10'd0, 10'd0, 10'd512, 10'd512,
                         16'h8000, 16'h7FFF, 16'hFFFF));
    // beyond-atlas corners clamp to the same point: zero width, advance only
    push_item(glyph_load(8'd66, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF,
                         16'h7FFF, 16'h8000, 16'h0100));
    // inverted in x: zero width
    push_item(glyph_load(8'd67, 10'd300, 10'd50, 10'd100, 10'd400,
                         16'h0000, 16'h0000, 16'h0800));
    // inverted in y: quad with zero height
    push_item(glyph_load(8'd68, 10'd10, 10'd400, 10'd200, 10'd20,
                         16'h0200, 16'hFE00, 16'h0A00));
    push_item(glyph_load(8'd127, 10'd511, 10'd0, 10'd512, 10'd1,
                         16'hFFFF, 16'h0001, 16'h0001));
    push_item(glyph_load(8'd32, 10'd0, 10'd0, 10'd0, 10'd0,
                         16'h0000, 16'h0000, 16'h0400));
    push_item(glyph_load(8'd200, 10'd1, 10'd2, 10'd3, 10'd4,
                         16'h1234, 16'h5678, 16'h9ABC));   // outside the table: dropped
    loaded_codes = '{65, 66, 67, 68, 127, 32};
    push_item(start_item(24'h7FFFFF, 24'h800000));          // pen at the corners
    push_item(char_item(8'd65));
    push_item(char_item(8'd66));
    push_item(char_item(8'd67));
    push_item(char_item(8'd68));
    push_item(char_item(CODE_NEWLINE));
    push_item(char_item(8'd0));
    push_item(char_item(8'd31));
    push_item(char_item(8'd127));
    push_item(char_item(8'd128));
    push_item(char_item(8'd255));
    push_item(char_item(8'd32));
    push_item(end_item());
    push_item(start_item(24'h800000, 24'h7FFFFF));          // quad x saturates low
    push_item(char_item(8'd65));
    push_item(end_item());
    drain();

    // Register settings per phase: extremes, midrange, random, then extremes again.
    plan[0] = '{scale: 16'd1, line_height: 16'd0, ascent: 16'h8000, max_width: 23'd0};
    plan[1] = '{scale: 16'hFFFF, line_height: 16'hFFFF, ascent: 16'h7FFF,
                max_width: 23'h7FFFFF};
    plan[2] = '{scale: 16'd4096, line_height: 16'd4096, ascent: 16'd3072,
                max_width: 23'($urandom_range(0, 200000))};
    plan[3] = '{scale: 16'($urandom_range(1, 65535)), line_height: 16'($urandom),
                ascent: 16'($urandom), max_width: 23'($urandom)};
    plan[4] = '{scale: 16'd2048, line_height: 16'd5120, ascent: 16'hFE00,
                max_width: 23'($urandom_range(0, 60000))};
    plan[5] = '{scale: 16'hFFFF, line_height: 16'd1, ascent: 16'd0, max_width: 23'd1000};

    for (ph = 0; ph < 6; ph++) begin
      // idle mix: sender-light first, then receiver-light, then none
      if (ph < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 56;
      end else if (ph < 4) begin
        send_idle_pct = 56;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_config(plan[ph]);

      if (ph == 4) begin
        // Backpressure: receiver stalls long while a dense text keeps coming,
        // so the result queue fills and full must hold the input off.
        for (c = 65; c <= 70; c++) begin
          x0 = $urandom_range(0, 400);
          push_item(glyph_load(8'(c), 10'(x0), 10'($urandom_range(0, 200)),
                               10'(x0 + $urandom_range(1, 100)), 10'($urandom_range(200, 512)),
                               16'($urandom), 16'($urandom), 16'($urandom_range(0, 16'h1000))));
          loaded_codes.push_back(c);
        end
        push_item(random_start());
        hold_left = 400;
        repeat (120) push_item(char_item(8'($urandom_range(65, 70))));
        push_item(end_item());
        drain();
      end

      random_traffic(80);
      drain();
    end

    $display("Checked %0d quads and %0d summaries from %0d items over %0d register settings.",
             mirror.n_quads, mirror.n_summaries, mirror.n_items, 7);
    $display("Covered table loads and clamps, skipped codes, newlines, saturation, fit limits",
             " and a long output stall.");
    if (mirror.n_bad == 0 && mirror.due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
